FILE: rtl/wcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly charge window table package
// Shared widths, command and status codes, item types and the time field check.
// ----------------------------------------------------------------------------
package wcw_pkg;

    // Table geometry and field widths.
    localparam int DAYS      = 7;
    localparam int DAY_IDX_W = $clog2(DAYS);
    localparam int DAY_W     = 3;
    localparam int COUNT_W   = 17;
    localparam int HOUR_W    = 5;
    localparam int MS_W      = 6;

    // Limits of the time fields.
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
    localparam logic [MS_W-1:0]   MINSEC_MAX = 6'd59;

    // Reciprocal of sixty: (x * RECIP_60) >> RECIP_SHIFT equals x / 60 for
    // every dividend of COUNT_W bits.
    localparam int                 RECIP_W     = 18;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP_60    = 18'd139811;
    localparam int                 PROD_W      = COUNT_W + RECIP_W;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DAY_ERR  = 2'd1;
    localparam logic [1:0] ST_TIME_ERR = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]        command;
        logic [DAY_W-1:0]  day_index;
        logic [HOUR_W-1:0] start_hour;
        logic [MS_W-1:0]   start_minute;
        logic [MS_W-1:0]   start_second;
        logic [HOUR_W-1:0] end_hour;
        logic [MS_W-1:0]   end_minute;
        logic [MS_W-1:0]   end_second;
        logic [HOUR_W-1:0] now_hour;
        logic [MS_W-1:0]   now_minute;
        logic [MS_W-1:0]   now_second;
        logic              clock_lost;
    } wcw_req_t;

    // One result item.
    typedef struct packed {
        logic [HOUR_W-1:0]  read_start_hour;
        logic [MS_W-1:0]    read_start_minute;
        logic [MS_W-1:0]    read_start_second;
        logic [HOUR_W-1:0]  read_end_hour;
        logic [MS_W-1:0]    read_end_minute;
        logic [MS_W-1:0]    read_end_second;
        logic [COUNT_W-1:0] read_start_count;
        logic [COUNT_W-1:0] read_end_count;
        logic               charge_allowed;
        logic [1:0]         status;
    } wcw_rsp_t;

    // Request to and response from the divide-by-sixty unit.
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quot;
        logic [MS_W-1:0]    rem;
    } div_rsp_t;

    // True when an hour:minute:second triple is a legal time of day.
    function automatic logic time_ok(
        input logic [HOUR_W-1:0] h,
        input logic [MS_W-1:0]   m,
        input logic [MS_W-1:0]   s
    );
        return (h <= HOUR_MAX) && (m <= MINSEC_MAX) && (s <= MINSEC_MAX);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wcw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly charge window table channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface wcw_req_if import wcw_pkg::*; ();
    logic     valid;
    logic     ready;
    wcw_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wcw_rsp_if import wcw_pkg::*; ();
    logic     valid;
    logic     ready;
    wcw_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/weekly_charge_window_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly charge window table
// Per-weekday charging windows with write, read and charge check commands.
// ----------------------------------------------------------------------------
// Usage:
// Command items enter on the request channel and each gives exactly one
// result item on the result channel. The block works on one item at a time:
// request.ready is high only while it is idle, and stays low until the result
// item has been taken. After the accepting edge, a write passes through a
// decode step and six digit steps of the shared multiply-by-sixty adder before
// its result item is valid. A check takes decode, three digit steps and one
// compare. A read takes decode and four divisions by sixty in the shared
// reciprocal unit, each a launch and a collect step. Errors, a lost clock and
// unused commands answer straight from the decode step. request.ready returns
// the cycle after the result item is taken. Reset clears all windows to zero,
// so no day allows charging until a window is written. When the receiver
// stalls, the result item waits in its register and no new item is taken.
// ----------------------------------------------------------------------------
module weekly_charge_window_table_unit import wcw_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wcw_req_if.sink    request,
    wcw_rsp_if.source  result
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_COMPOSE    = 3'd2;
    localparam logic [2:0] S_SPLIT_GO   = 3'd3;
    localparam logic [2:0] S_SPLIT_WAIT = 3'd4;
    localparam logic [2:0] S_CHECK      = 3'd5;
    localparam logic [2:0] S_OUT        = 3'd6;

    localparam logic [DAY_W:0] DAY_LIMIT = (DAY_W + 1)'(DAYS);

    logic [2:0]         state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    wcw_req_t           item_reg, item_next;
    wcw_rsp_t           res_reg, res_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] start_tbl_reg [DAYS];
    logic [COUNT_W-1:0] end_tbl_reg [DAYS];
    logic               start_we;
    logic               end_we;
    logic [DAY_IDX_W-1:0] idx;
    logic               day_ok;
    logic [MS_W-1:0]    digit;
    logic [COUNT_W-1:0] acc_x60;
    logic [COUNT_W-1:0] win_start;
    logic [COUNT_W-1:0] win_end;
    logic               allow;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Shared divide-by-sixty unit.
    wcw_div60 u_div60 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign idx       = item_reg.day_index[DAY_IDX_W-1:0];
    assign day_ok    = ({1'b0, item_reg.day_index} < DAY_LIMIT);
    assign win_start = start_tbl_reg[idx];
    assign win_end   = end_tbl_reg[idx];

    // Multiply by sixty as 64x - 4x; the true product always fits.
    assign acc_x60 = {acc_reg[COUNT_W-7:0], 6'b0} - {acc_reg[COUNT_W-3:0], 2'b0};

    // Time digit for the current compose step.
    always_comb
    begin
        digit = '0;
        if (item_reg.command == CMD_WRITE)
        begin
            unique case (step_reg)
                3'd0:    digit = {1'b0, item_reg.start_hour};
                3'd1:    digit = item_reg.start_minute;
                3'd2:    digit = item_reg.start_second;
                3'd3:    digit = {1'b0, item_reg.end_hour};
                3'd4:    digit = item_reg.end_minute;
                3'd5:    digit = item_reg.end_second;
                default: digit = '0;
            endcase
        end
        else
        begin
            unique case (step_reg)
                3'd0:    digit = {1'b0, item_reg.now_hour};
                3'd1:    digit = item_reg.now_minute;
                default: digit = item_reg.now_second;
            endcase
        end
    end

    // Window test, with wrap past midnight when start lies after end.
    always_comb
    begin
        allow = 1'b0;
        if (win_start < win_end)
        begin
            allow = (acc_reg >= win_start) && (acc_reg < win_end);
        end
        else if (win_start > win_end)
        begin
            allow = (acc_reg >= win_start) || (acc_reg < win_end);
        end
    end

    // Command sequencer.
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        acc_next         = acc_reg;
        start_we         = 1'b0;
        end_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = acc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    item_next  = request.data;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next   = '0;
                step_next  = '0;
                state_next = S_OUT;
                unique case (item_reg.command)
                    CMD_WRITE:
                    begin
                        if (!day_ok)
                        begin
                            res_next.status = ST_DAY_ERR;
                        end
                        else if (!time_ok(item_reg.start_hour, item_reg.start_minute,
                                          item_reg.start_second) ||
                                 !time_ok(item_reg.end_hour, item_reg.end_minute,
                                          item_reg.end_second))
                        begin
                            res_next.status = ST_TIME_ERR;
                        end
                        else
                        begin
                            state_next = S_COMPOSE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!day_ok)
                        begin
                            res_next.status = ST_DAY_ERR;
                        end
                        else
                        begin
                            res_next.read_start_count = win_start;
                            res_next.read_end_count   = win_end;
                            state_next                = S_SPLIT_GO;
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (item_reg.clock_lost)
                        begin
                            res_next.status = ST_OK;
                        end
                        else if (!day_ok)
                        begin
                            res_next.status = ST_DAY_ERR;
                        end
                        else if (!time_ok(item_reg.now_hour, item_reg.now_minute,
                                          item_reg.now_second))
                        begin
                            res_next.status = ST_TIME_ERR;
                        end
                        else
                        begin
                            state_next = S_COMPOSE;
                        end
                    end
                    CMD_NONE:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end

            // One digit per cycle: acc = acc * 60 + digit, restarting at each hour.
            S_COMPOSE:
            begin
                if ((step_reg == 3'd0) || (step_reg == 3'd3))
                begin
                    acc_next = COUNT_W'(digit);
                end
                else
                begin
                    acc_next = acc_x60 + COUNT_W'(digit);
                end
                step_next = step_reg + 1'b1;
                if (item_reg.command == CMD_WRITE)
                begin
                    if (step_reg == 3'd2)
                    begin
                        start_we = 1'b1;
                    end
                    if (step_reg == 3'd5)
                    begin
                        end_we     = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else if (step_reg == 3'd2)
                begin
                    state_next = S_CHECK;
                end
            end

            // Launch a division: each stored count, then its quotient.
            S_SPLIT_GO:
            begin
                div_req.start = 1'b1;
                if (step_reg == 3'd0)
                begin
                    div_req.dividend = win_start;
                end
                else if (step_reg == 3'd2)
                begin
                    div_req.dividend = win_end;
                end
                state_next = S_SPLIT_WAIT;
            end

            S_SPLIT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    acc_next  = div_rsp.quot;
                    step_next = step_reg + 1'b1;
                    unique case (step_reg)
                        3'd0:
                        begin
                            res_next.read_start_second = div_rsp.rem;
                        end
                        3'd1:
                        begin
                            res_next.read_start_minute = div_rsp.rem;
                            res_next.read_start_hour   = div_rsp.quot[HOUR_W-1:0];
                        end
                        3'd2:
                        begin
                            res_next.read_end_second = div_rsp.rem;
                        end
                        default:
                        begin
                            res_next.read_end_minute = div_rsp.rem;
                            res_next.read_end_hour   = div_rsp.quot[HOUR_W-1:0];
                        end
                    endcase
                    state_next = (step_reg == 3'd3) ? S_OUT : S_SPLIT_GO;
                end
            end

            S_CHECK:
            begin
                res_next.charge_allowed = allow;
                state_next              = S_OUT;
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the window tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            for (int i = 0; i < DAYS; i++)
            begin
                start_tbl_reg[i] <= '0;
                end_tbl_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (start_we)
            begin
                start_tbl_reg[idx] <= acc_next;
            end
            if (end_we)
            begin
                end_tbl_reg[idx] <= acc_next;
            end
        end
    end

    // Item, working value and result registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
    end

    assign request.ready = (state_reg == S_IDLE);
    assign result.valid  = (state_reg == S_OUT);
    assign result.data   = res_reg;

`ifndef SYNTHESIS
    // The block never takes an item while a result item is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(request.ready && result.valid))
        else $error("request taken while a result item is pending");

    // A divider answer only arrives while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_SPLIT_WAIT))
        else $error("divider finished outside of a read");

    // An accepted item is decoded in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> (state_reg == S_DECODE))
        else $error("accepted item was not decoded");
`endif

endmodule
`default_nettype wire

FILE: rtl/wcw_div60.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divide by sixty
// Quotient and remainder by sixty through a reciprocal multiplication,
// registered in the cycle after the start request.
// ----------------------------------------------------------------------------
module wcw_div60 import wcw_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 done_reg, done_next;
    logic [COUNT_W-1:0]   quot_reg, quot_next;
    logic [MS_W-1:0]      rem_reg, rem_next;
    logic [PROD_W-1:0]    product;
    logic [COUNT_W-1:0]   quot;
    logic [MS_W-1:0]      rem;

    // Quotient from the scaled reciprocal.
    assign product = PROD_W'(req.dividend) * PROD_W'(RECIP_60);
    assign quot    = COUNT_W'(product[PROD_W-1:RECIP_SHIFT]);

    // The remainder is below 64, so it is x - 60q taken modulo 64, which
    // equals x + 4q modulo 64.
    assign rem = req.dividend[MS_W-1:0] + {quot[MS_W-3:0], 2'b00};

    always_comb
    begin
        done_next = req.start;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            quot_next = quot;
            rem_next  = rem;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Quotient and remainder.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire
